// ===== design/ptts_pkg.sv =====
// Shared types and codes for the periodic task timer scheduler.
// Holds item and result codes, stream widths and the controller/datapath
// command and status structs. Depends on nothing.
package ptts_pkg;

    // input item kinds (s_tuser)
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // result kinds (m_tuser)
    localparam logic [1:0] RES_ASSIGNED = 2'd0;
    localparam logic [1:0] RES_EXPIRED  = 2'd1;
    localparam logic [1:0] RES_REJECTED = 2'd2;

    localparam int KIND_W      = 2;
    localparam int IN_PERIOD_W = 24;
    localparam int ID_W        = 4;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    typedef struct packed {
        logic capture;      // register the fields of an add transaction
        logic cancel;       // apply a cancel from the input bus
        logic add_commit;   // claim a slot and load the add result
        logic scan_start;   // rewind the slot scan
        logic scan_commit;  // update or retire the slot under the scan pointer
        logic flush;        // deliver the held expiry with last set
    } ptts_cmd_t;

    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic report_stall; // slot would report but the held expiry cannot move
        logic idx_last;     // scan pointer is at the top slot
        logic pend_valid;   // an expiry is held back for its last flag
    } ptts_status_t;

endpackage

// ===== design/ptts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ptts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ptts_ctrl.sv =====
// Controller state machine of the timer scheduler.
// Sequences add, cancel and tick transactions; depends on ptts_pkg.
module ptts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           kind,
    input  ptts_pkg::ptts_status_t st,
    output ptts_pkg::ptts_cmd_t  cmd
);
    import ptts_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_PRIME = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (kind)
                        KIND_TICK: begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_PRIME;
                        end
                        KIND_ADD: begin
                            cmd.capture = 1'b1;
                            state_next  = S_ADD;
                        end
                        KIND_CANCEL: begin
                            cmd.cancel = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD: begin
                if (st.out_free) begin
                    cmd.add_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PRIME: begin
                // read of slot zero is in flight
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (!st.report_stall) begin
                    cmd.scan_commit = 1'b1;
                    if (st.idx_last) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!st.pend_valid) begin
                    state_next = S_IDLE;
                end else if (st.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !st.pend_valid)
        else $error("expiry held while idle");

    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.cancel, cmd.add_commit, cmd.scan_start, cmd.scan_commit, cmd.flush}))
        else $error("more than one datapath action in a cycle");

    a_prime_then_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PRIME) |=> (state_reg == S_SCAN))
        else $error("scan did not follow prime");

endmodule

// ===== design/ptts_datapath.sv =====
// Datapath of the timer scheduler: slot flags, period/remaining RAM,
// scan pointer, held expiry and output register. Depends on ptts_pkg, ptts_ram.
module ptts_datapath #(
    parameter int NUM_SLOTS   = 16,
    parameter int PERIOD_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ptts_pkg::S_TDATA_W-1:0]    s_tdata,
    input  ptts_pkg::ptts_cmd_t               cmd,
    output ptts_pkg::ptts_status_t            st,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ptts_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [ptts_pkg::KIND_W-1:0]       m_tuser,
    output logic                              m_tlast
);
    import ptts_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int RAM_W  = 2 * PERIOD_BITS;
    localparam logic [32:0] PMAX = (33'd1 << PERIOD_BITS) - 33'd1;

    // input fields
    logic [IN_PERIOD_W-1:0] in_period;
    logic                   in_periodic;
    logic [ID_W-1:0]        in_cslot;

    assign in_period   = s_tdata[IN_PERIOD_W-1:0];
    assign in_periodic = s_tdata[IN_PERIOD_W];
    assign in_cslot    = s_tdata[IN_PERIOD_W+ID_W:IN_PERIOD_W+1];

    logic [NUM_SLOTS-1:0]   busy_reg, en_reg, rep_reg;
    logic [NUM_SLOTS-1:0]   busy_next, en_next, rep_next;
    logic [PERIOD_BITS-1:0] per_cap_reg;
    logic                   rep_cap_reg;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   pend_valid_reg;
    logic [ID_W-1:0]        pend_id_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_kind_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic                   out_last_reg;

    // period clamp and zero fix
    logic [PERIOD_BITS-1:0] per_sat;
    always_comb begin
        if ({9'd0, in_period} > PMAX) begin
            per_sat = PMAX[PERIOD_BITS-1:0];
        end else begin
            per_sat = PERIOD_BITS'(in_period);
        end
        if (per_sat == '0) begin
            per_sat = PERIOD_BITS'(1);
        end
    end

    // lowest free slot
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // RAM word: period in the upper half, remaining ticks in the lower
    logic [RAM_W-1:0]       rd_word;
    logic [PERIOD_BITS-1:0] rd_per, rd_rem, dec_rem, new_rem;
    logic                   zero, cur_busy, cur_en, cur_rep, report, retire_free;
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [RAM_W-1:0]       ram_wdata;

    assign rd_per   = rd_word[RAM_W-1:PERIOD_BITS];
    assign rd_rem   = rd_word[PERIOD_BITS-1:0];
    assign dec_rem  = (rd_rem != '0) ? rd_rem - PERIOD_BITS'(1) : '0;
    assign zero     = (dec_rem == '0);
    assign new_rem  = zero ? ((rd_per == '0) ? PERIOD_BITS'(1) : rd_per) : dec_rem;
    assign cur_busy = busy_reg[idx_reg];
    assign cur_en   = en_reg[idx_reg];
    assign cur_rep  = rep_reg[idx_reg];
    assign report   = cur_busy && zero && cur_en && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign retire_free = cur_busy && zero && !(cur_en && cur_rep);

    always_comb begin
        if (cmd.scan_commit) begin
            idx_next = (idx_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0 : idx_reg + SLOT_W'(1);
        end else if (cmd.scan_start) begin
            idx_next = '0;
        end else begin
            idx_next = idx_reg;
        end
    end

    always_comb begin
        if (cmd.add_commit) begin
            ram_we    = free_found;
            ram_waddr = free_idx;
            ram_wdata = {per_cap_reg, per_cap_reg};
        end else begin
            ram_we    = cmd.scan_commit && cur_busy && !retire_free;
            ram_waddr = idx_reg;
            ram_wdata = {rd_per, new_rem};
        end
    end

    ptts_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_next),
        .rdata (rd_word)
    );

    // slot flags
    logic [6:0] cs_ext;
    assign cs_ext = 7'(in_cslot);

    always_comb begin
        busy_next = busy_reg;
        en_next   = en_reg;
        rep_next  = rep_reg;
        if (cmd.cancel) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (cs_ext == 7'(i) && busy_reg[i] && en_reg[i]) begin
                    en_next[i]  = 1'b0;
                    rep_next[i] = 1'b0;
                end
            end
        end
        if (cmd.add_commit && free_found) begin
            busy_next[free_idx] = 1'b1;
            en_next[free_idx]   = 1'b1;
            rep_next[free_idx]  = rep_cap_reg;
        end
        if (cmd.scan_commit && retire_free) begin
            busy_next[idx_reg] = 1'b0;
            en_next[idx_reg]   = 1'b0;
            rep_next[idx_reg]  = 1'b0;
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= '0;
            en_reg         <= '0;
            rep_reg        <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            en_reg   <= en_next;
            rep_reg  <= rep_next;
            idx_reg  <= idx_next;

            if (cmd.scan_start) begin
                cnt_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end else if (cmd.scan_commit && report) begin
                cnt_reg        <= cnt_reg + CNT_W'(1);
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end

            if (cmd.add_commit || cmd.flush || (cmd.scan_commit && report && pend_valid_reg)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            per_cap_reg <= per_sat;
            rep_cap_reg <= in_periodic;
        end
        if (cmd.scan_commit && report) begin
            pend_id_reg <= ID_W'(idx_reg);
        end
        if (cmd.add_commit) begin
            out_kind_reg <= free_found ? RES_ASSIGNED : RES_REJECTED;
            out_id_reg   <= free_found ? ID_W'(free_idx) : '0;
            out_last_reg <= 1'b1;
        end else if (cmd.flush) begin
            out_kind_reg <= RES_EXPIRED;
            out_id_reg   <= pend_id_reg;
            out_last_reg <= 1'b1;
        end else if (cmd.scan_commit && report && pend_valid_reg) begin
            // push the earlier expiry out, a later one follows it
            out_kind_reg <= RES_EXPIRED;
            out_id_reg   <= pend_id_reg;
            out_last_reg <= 1'b0;
        end
    end

    assign st.out_free     = out_free;
    assign st.report_stall = report && pend_valid_reg && !out_free;
    assign st.idx_last     = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign st.pend_valid   = pend_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_id_reg);
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("expiry count beyond cap");

    a_add_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_commit |-> out_free)
        else $error("add result loaded over an untaken result");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_commit && report && pend_valid_reg) |-> out_free)
        else $error("expiry pushed over an untaken result");

endmodule

// ===== design/periodic_task_timer_scheduler_unit.sv =====
// Top level of the periodic task timer scheduler.
// Joins ptts_ctrl and ptts_datapath; depends on ptts_pkg.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tuser kind, s_tdata period/mode/slot
//  m_        out        m_tvalid / m_tready  m_tuser result kind, m_tdata id, m_tlast
//
// A cancel is applied as it is taken. An add is taken, then committed once
// the output register is free. A tick takes the transaction, primes the slot
// RAM read, scans one slot per cycle through its single read port unless a
// held expiry cannot leave because m_tready is low, then delivers the final
// expiry, if any. Items are taken one at a time.
// After reset all slots are free at once; the RAM needs no clearing pass.
module periodic_task_timer_scheduler_unit #(
    parameter int NUM_SLOTS   = 16,
    parameter int PERIOD_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [23:0] period_ticks, [24] periodic, [28:25] cancel_slot, [31:29] zero
    input  logic [ptts_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [ptts_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] slot_id, [7:4] zero
    output logic [ptts_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] result_kind
    output logic [ptts_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);
    import ptts_pkg::*;

    ptts_cmd_t    cmd;
    ptts_status_t st;

    ptts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    ptts_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
